// File: rtl/core/lcdrs_pkg.sv
`default_nettype none

package lcdrs_pkg;

  // display geometry
  localparam int PAGE_COUNT   = 8;
  localparam int HALF_COLUMNS = 64;
  localparam int ROW_BYTES    = 16;
  localparam int PAGE_ROWS    = 8;

  localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W    = $clog2(HALF_COLUMNS);
  localparam int BCOL_W   = $clog2(ROW_BYTES);
  localparam int FB_AW    = PAGE_W + BCOL_W;
  localparam int FB_DEPTH = PAGE_COUNT * ROW_BYTES;
  localparam int BANK_W   = $clog2(PAGE_ROWS);
  localparam int UPC_W    = 4;

  // display controller bytes
  localparam logic [7:0] CMD_ON   = 8'h3F;
  localparam logic [7:0] CMD_PAGE = 8'hB8;
  localparam logic [7:0] CMD_COL  = 8'h40;
  localparam logic [7:0] FILL_ON  = 8'hFF;
  localparam logic [7:0] FILL_OFF = 8'h00;

  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_INIT  = 3'd1,
    FUNC_FILL  = 3'd2,
    FUNC_SHOW  = 3'd3,
    FUNC_STEP  = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0] func;
    logic [9:0] addr;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic       half_select;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  // transfer described by the current control word
  typedef struct packed {
    logic       emit;
    logic       is_data;
    logic       half_select;
    logic [7:0] bus_byte;
    logic       last;
    logic       show;
    logic [2:0] bit_sel;
  } xfer_t;

  // frame buffer write request
  typedef struct packed {
    logic              en;
    logic              all;
    logic [BANK_W-1:0] bank;
    logic [FB_AW-1:0]  addr;
    logic [7:0]        data;
  } fb_wr_t;

  typedef logic [PAGE_ROWS-1:0][7:0] fb_word_t;

  // microcode
  typedef enum logic [2:0] {
    SRC_ON   = 3'd0,
    SRC_PAGE = 3'd1,
    SRC_COL  = 3'd2,
    SRC_FILL = 3'd3,
    SRC_SHOW = 3'd4
  } byte_src_t;

  typedef enum logic [1:0] {
    COND_SEQ  = 2'd0,
    COND_COL  = 2'd1,
    COND_PAGE = 2'd2
  } cond_t;

  typedef struct packed {
    byte_src_t        src;
    logic             half;
    logic             is_data;
    cond_t            cond;
    logic [UPC_W-1:0] nxt;
  } uword_t;

  localparam logic [UPC_W-1:0] UPC_INIT = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_FILL = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_SHOW = UPC_W'(8);

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      4'd0:    w = '{SRC_ON,   1'b0, 1'b0, COND_SEQ,  4'd1};
      4'd1:    w = '{SRC_ON,   1'b1, 1'b0, COND_SEQ,  UPC_FILL};
      4'd2:    w = '{SRC_PAGE, 1'b0, 1'b0, COND_SEQ,  4'd3};
      4'd3:    w = '{SRC_COL,  1'b0, 1'b0, COND_SEQ,  4'd4};
      4'd4:    w = '{SRC_FILL, 1'b0, 1'b1, COND_COL,  4'd5};
      4'd5:    w = '{SRC_PAGE, 1'b1, 1'b0, COND_SEQ,  4'd6};
      4'd6:    w = '{SRC_COL,  1'b1, 1'b0, COND_SEQ,  4'd7};
      4'd7:    w = '{SRC_FILL, 1'b1, 1'b1, COND_PAGE, UPC_FILL};
      4'd8:    w = '{SRC_PAGE, 1'b0, 1'b0, COND_SEQ,  4'd9};
      4'd9:    w = '{SRC_COL,  1'b0, 1'b0, COND_SEQ,  4'd10};
      4'd10:   w = '{SRC_SHOW, 1'b0, 1'b1, COND_PAGE, UPC_SHOW};
      default: w = '{SRC_ON,   1'b0, 1'b0, COND_SEQ,  UPC_INIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcdrs_fbuf.sv
`default_nettype none

module lcdrs_fbuf (
  input  logic                        clk,
  input  lcdrs_pkg::fb_wr_t           wr,
  input  logic                        rd_en,
  input  logic [lcdrs_pkg::FB_AW-1:0] rd_addr,
  output lcdrs_pkg::fb_word_t         rd_data
);
  import lcdrs_pkg::*;

  // one bank per row within a page, all read together
  for (genvar b = 0; b < PAGE_ROWS; b++) begin : g_bank
    logic [7:0] mem_r [FB_DEPTH];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr.en && (wr.all || wr.bank == BANK_W'(b))) begin
        mem_r[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        rd_r <= mem_r[rd_addr];
      end
    end

    assign rd_data[b] = rd_r;
  end

endmodule

`default_nettype wire

// File: rtl/core/lcdrs_seq.sv
`default_nettype none

module lcdrs_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  lcdrs_pkg::in_item_t         item,
  output lcdrs_pkg::xfer_t            xfer,
  output logic [lcdrs_pkg::FB_AW-1:0] rd_addr
);
  import lcdrs_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [7:0]       fill_r, fill_nxt;

  uword_t uw;
  logic   col_end;
  logic   page_last;
  logic [7:0] byte_val;

  assign uw        = ucode_rom(upc_r);
  assign col_end   = (col_r == COL_W'(HALF_COLUMNS - 1));
  assign page_last = (page_r == PAGE_W'(PAGE_COUNT - 1));
  assign rd_addr   = {page_r, BCOL_W'(col_r >> 3)};

  always_comb begin
    unique case (uw.src)
      SRC_ON:   byte_val = CMD_ON;
      SRC_PAGE: byte_val = CMD_PAGE | 8'(page_r);
      SRC_COL:  byte_val = CMD_COL;
      SRC_FILL: byte_val = fill_r;
      SRC_SHOW: byte_val = 8'h00;
      default:  byte_val = 8'h00;
    endcase
  end

  always_comb begin
    xfer.emit        = busy_r;
    xfer.is_data     = uw.is_data;
    xfer.half_select = uw.half;
    xfer.bus_byte    = byte_val;
    xfer.last        = (uw.cond == COND_PAGE) && col_end && page_last;
    xfer.show        = (uw.src == SRC_SHOW);
    xfer.bit_sel     = col_r[2:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    page_nxt = page_r;
    col_nxt  = col_r;
    fill_nxt = fill_r;
    if (go) begin
      if (item.func == FUNC_STEP && busy_r) begin
        unique case (uw.cond)
          COND_SEQ: upc_nxt = uw.nxt;
          COND_COL: begin
            if (col_end) begin
              col_nxt = '0;
              upc_nxt = uw.nxt;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          COND_PAGE: begin
            if (!col_end) begin
              col_nxt = col_r + 1'b1;
            end else begin
              col_nxt = '0;
              if (page_last) begin
                busy_nxt = 1'b0;
                page_nxt = '0;
              end else begin
                page_nxt = page_r + 1'b1;
                upc_nxt  = uw.nxt;
              end
            end
          end
          default: upc_nxt = uw.nxt;
        endcase
      end else if (!busy_r) begin
        // starts are ignored while a sequence runs
        priority if (item.func == FUNC_INIT) begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_INIT;
          page_nxt = '0;
          col_nxt  = '0;
          fill_nxt = FILL_OFF;
        end else if (item.func == FUNC_FILL) begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_FILL;
          page_nxt = '0;
          col_nxt  = '0;
          fill_nxt = (item.value != 8'h00) ? FILL_ON : FILL_OFF;
        end else if (item.func == FUNC_SHOW) begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_SHOW;
          page_nxt = '0;
          col_nxt  = '0;
        end else begin
          busy_nxt = busy_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_INIT;
      page_r <= '0;
      col_r  <= '0;
      fill_r <= FILL_OFF;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      page_r <= page_nxt;
      col_r  <= col_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/page_lcd_refresh_sequencer_top.sv
// a step that yields a transfer loads exec_r and the bank reads, then out_valid_r
// throughput: write, start and idle step transactions one per cycle unless stalled;
//   a transferring step holds in_stall while the eight frame buffer banks are read
// reset: synchronous active low; afterwards a clearing pass zeroes the buffer,
//   one row of all eight banks per cycle, with in_stall held high
`default_nettype none

module page_lcd_refresh_sequencer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcdrs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdrs_pkg::out_item_t out_data
);
  import lcdrs_pkg::*;

  // clearing pass after reset
  logic             clr_r, clr_nxt;
  logic [FB_AW-1:0] clr_addr_r, clr_addr_nxt;

  // buffer read stage between a step transaction and its result
  logic      exec_r, exec_nxt;
  xfer_t     pend_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic     acc;
  logic     step_acc;
  xfer_t    xfer;
  fb_wr_t   fb_wr;
  fb_word_t fb_rd;
  logic [FB_AW-1:0] rd_addr;
  logic [7:0] show_byte;

  // input is held off while clearing, while a read is in flight, or
  // while a finished transfer still waits downstream
  assign in_stall = clr_r || exec_r || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign step_acc = acc && (in_data.func == FUNC_STEP);

  // buffer write port: clearing pass writes a zero to every bank
  always_comb begin
    if (clr_r) begin
      fb_wr.en   = 1'b1;
      fb_wr.all  = 1'b1;
      fb_wr.bank = '0;
      fb_wr.addr = clr_addr_r;
      fb_wr.data = 8'h00;
    end else begin
      // bank is the row within the page, address is page and byte column
      fb_wr.en   = acc && (in_data.func == FUNC_WRITE);
      fb_wr.all  = 1'b0;
      fb_wr.bank = in_data.addr[BCOL_W +: BANK_W];
      fb_wr.addr = {in_data.addr[BCOL_W + BANK_W +: PAGE_W], in_data.addr[BCOL_W-1:0]};
      fb_wr.data = in_data.value;
    end
  end

  lcdrs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (acc),
    .item    (in_data),
    .xfer    (xfer),
    .rd_addr (rd_addr)
  );

  // the read is taken at the step's acceptance edge, so later writes cannot race it
  lcdrs_fbuf u_fbuf (
    .clk     (clk),
    .wr      (fb_wr),
    .rd_en   (step_acc),
    .rd_addr (rd_addr),
    .rd_data (fb_rd)
  );

  // column byte: bit r comes from row r of the page, pixel picked MSB first
  always_comb begin
    for (int r = 0; r < PAGE_ROWS; r++) begin
      show_byte[r] = fb_rd[r][~pend_r.bit_sel];
    end
  end

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == FB_AW'(FB_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  assign exec_nxt = step_acc && xfer.emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      exec_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      exec_r      <= exec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (exec_nxt) begin
      pend_r <= xfer;
    end
    if (exec_r) begin
      out_data_r.is_data     <= pend_r.is_data;
      out_data_r.half_select <= pend_r.half_select;
      out_data_r.bus_byte    <= pend_r.show ? show_byte : pend_r.bus_byte;
      out_data_r.last        <= pend_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/lcdrs_chk.sv
`default_nettype none

module lcdrs_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input lcdrs_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input lcdrs_pkg::out_item_t out_data
);
  import lcdrs_pkg::*;

  // stalled transfer is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled transfer keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // every new result comes from an accepted step transaction
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.func == FUNC_STEP, 2))
    else $error("result without a step transaction");

  // a waiting result holds off the input side
  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while a result waits");

  // clearing pass follows reset
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input accepted during clearing pass");

endmodule

bind page_lcd_refresh_sequencer_top lcdrs_chk u_lcdrs_chk (.*);

`default_nettype wire
